>>> rtl/core/vrs_pkg.sv
// ----------------------------------------------------------------------------
// vrs_pkg: shared types and constants of the voxel running average store
// Holds the controller states, the command and status groups passed between
// the controller and the datapath, and the fixed field codes and widths.
// ----------------------------------------------------------------------------
package vrs_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SLICE_AXIS = 2'd0;
  localparam logic [1:0] CFG_DIM_X      = 2'd1;
  localparam logic [1:0] CFG_DIM_Y      = 2'd2;
  localparam logic [1:0] CFG_DIM_Z      = 2'd3;

  // Slicing axis codes; the unused code behaves as the z axis.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;

  // Request opcodes.
  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [1:0] SLICE_AXIS_RST = 2'd2;
  localparam logic [4:0] DIM_RST        = 5'd10;

  // Field widths.
  localparam int CFG_W     = 5;
  localparam int COORD_W   = 4;
  localparam int BYTE_W    = 8;
  localparam int MEAN_W    = 16;  // 8.8 fixed point per channel
  localparam int CHANNELS  = 4;
  localparam int MEANS_W   = MEAN_W * CHANNELS;
  localparam int STEP_CNT_W = $clog2(MEAN_W);

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_FETCH,
    ST_DIVIDE,
    ST_WRITE,
    ST_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the accepted request
    logic clr_wr;      // write one zero entry of the clearing sweep
    logic load_color;  // take the stored means as the read result
    logic start_div;   // form numerators and load the divider
    logic div_step;    // one restoring division step
    logic mem_wr;      // write back the updated voxel
    logic load_out;    // move the result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;    // clearing sweep is at its last entry
    logic in_range;    // captured coordinates are inside the grid
    logic is_read;     // captured request is a read
    logic covered;     // captured pixel is covered
    logic div_last;    // divider is on its last step
    logic out_free;    // output register can take a result
  } ctrl_sts_t;

endpackage

>>> rtl/core/vrs_ram.sv
// ----------------------------------------------------------------------------
// vrs_ram: generic single-port RAM
// One address per cycle, write when enabled, read data registered.
// ----------------------------------------------------------------------------
module vrs_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read first: the array takes the write, the read returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/core/vrs_div.sv
// ----------------------------------------------------------------------------
// vrs_div: four-lane iterative restoring divider
// All lanes share one divisor and produce one quotient bit per step each.
// The quotient is known to fit in one 8.8 mean, so sixteen steps suffice.
// ----------------------------------------------------------------------------
module vrs_div #(
  parameter int COUNT_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic step,
  input  logic [COUNT_BITS:0] divisor,
  input  logic [COUNT_BITS+vrs_pkg::MEAN_W:0] num [vrs_pkg::CHANNELS],
  output logic [vrs_pkg::MEAN_W-1:0] quo [vrs_pkg::CHANNELS],
  output logic last
);

  import vrs_pkg::*;

  localparam int REM_W = COUNT_BITS + 1;
  localparam int NUM_W = COUNT_BITS + MEAN_W + 1;

  logic [REM_W-1:0]      rem [CHANNELS];
  logic [REM_W-1:0]      rem_next [CHANNELS];
  logic [MEAN_W-1:0]     quo_next [CHANNELS];
  logic [REM_W-1:0]      dvs;
  logic [STEP_CNT_W-1:0] cnt;

  // One restoring step per lane: shift in the next numerator bit, try the subtract.
  always_comb begin
    logic [REM_W:0] trial;
    logic           ge;
    for (int i = 0; i < CHANNELS; i++) begin
      trial       = {rem[i], quo[i][MEAN_W-1]};
      ge          = (trial >= {1'b0, dvs});
      rem_next[i] = ge ? REM_W'(trial - {1'b0, dvs}) : trial[REM_W-1:0];
      quo_next[i] = {quo[i][MEAN_W-2:0], ge};
    end
  end

  // Lane registers; the upper numerator part is already below the divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      for (int i = 0; i < CHANNELS; i++) begin
        rem[i] <= num[i][NUM_W-1:MEAN_W];
        quo[i] <= num[i][MEAN_W-1:0];
      end
    end else if (step) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rem[i] <= rem_next[i];
        quo[i] <= quo_next[i];
      end
    end
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign last = (cnt == STEP_CNT_W'(MEAN_W - 1));

endmodule

>>> rtl/core/vrs_ctrl.sv
// ----------------------------------------------------------------------------
// vrs_ctrl: controller of the voxel running average store
// Sequences the clearing sweep, the voxel lookup, the division and the
// write-back, and hands each result to the output register.
// ----------------------------------------------------------------------------
module vrs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  vrs_pkg::ctrl_sts_t  sts,
  output vrs_pkg::ctrl_cmd_t  cmd
);

  import vrs_pkg::*;

  state_t state;
  state_t state_next;

  // State register; reset starts the clearing sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // The RAM reads the captured address during this cycle.
        state_next = sts.in_range ? ST_FETCH : ST_RESULT;
      end
      ST_FETCH: begin
        if (sts.is_read) begin
          cmd.load_color = 1'b1;
          state_next     = ST_RESULT;
        end else if (!sts.covered) begin
          state_next = ST_RESULT;
        end else begin
          cmd.start_div = 1'b1;
          state_next    = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.mem_wr = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

>>> rtl/core/vrs_dp.sv
// ----------------------------------------------------------------------------
// vrs_dp: datapath of the voxel running average store
// Configuration registers, voxel address and range check, the voxel RAM,
// the running mean update through the divider, and the output register.
// ----------------------------------------------------------------------------
module vrs_dp #(
  parameter int GRID_SIDE  = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [vrs_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          opcode,
  input  logic [vrs_pkg::COORD_W-1:0]   layer,
  input  logic [vrs_pkg::COORD_W-1:0]   col,
  input  logic [vrs_pkg::COORD_W-1:0]   row,
  input  logic [vrs_pkg::BYTE_W-1:0]    red_in,
  input  logic [vrs_pkg::BYTE_W-1:0]    green_in,
  input  logic [vrs_pkg::BYTE_W-1:0]    blue_in,
  input  logic [vrs_pkg::BYTE_W-1:0]    alpha_in,
  input  logic                          covered,
  input  vrs_pkg::ctrl_cmd_t            cmd,
  output vrs_pkg::ctrl_sts_t            sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vrs_pkg::BYTE_W-1:0]    red_out,
  output logic [vrs_pkg::BYTE_W-1:0]    green_out,
  output logic [vrs_pkg::BYTE_W-1:0]    blue_out,
  output logic [vrs_pkg::BYTE_W-1:0]    alpha_out,
  output logic                          status
);

  import vrs_pkg::*;

  localparam int CELLS   = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int ENTRY_W = MEANS_W + COUNT_BITS;
  localparam int NUM_W   = COUNT_BITS + MEAN_W + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Configuration registers.
  logic [1:0]       slice_axis;
  logic [CFG_W-1:0] dim_x;
  logic [CFG_W-1:0] dim_y;
  logic [CFG_W-1:0] dim_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_axis <= SLICE_AXIS_RST;
      dim_x      <= DIM_RST;
      dim_y      <= DIM_RST;
      dim_z      <= DIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLICE_AXIS: slice_axis <= cfg_data[1:0];
        CFG_DIM_X:      dim_x      <= cfg_data;
        CFG_DIM_Y:      dim_y      <= cfg_data;
        CFG_DIM_Z:      dim_z      <= cfg_data;
      endcase
    end
  end

  // Map the slice pixel onto grid coordinates and check them.
  logic [COORD_W-1:0] vx;
  logic [COORD_W-1:0] vy;
  logic [COORD_W-1:0] vz;
  logic               range_ok;
  logic [31:0]        addr_wide;

  always_comb begin
    if (slice_axis == AXIS_X) begin
      vx = layer; vy = col;   vz = row;
    end else if (slice_axis == AXIS_Y) begin
      vx = col;   vy = layer; vz = row;
    end else begin
      vx = col;   vy = row;   vz = layer;
    end
    range_ok = ({1'b0, vx} < dim_x) && (32'(vx) < 32'(GRID_SIDE)) &&
               ({1'b0, vy} < dim_y) && (32'(vy) < 32'(GRID_SIDE)) &&
               ({1'b0, vz} < dim_z) && (32'(vz) < 32'(GRID_SIDE));
    addr_wide = 32'(vx) + 32'(vy) * 32'(GRID_SIDE) +
                32'(vz) * 32'(GRID_SIDE * GRID_SIDE);
  end

  // Captured request.
  logic              op_q;
  logic              cov_q;
  logic              in_range_q;
  logic [ADDR_W-1:0] addr_q;
  logic [BYTE_W-1:0] px_q [CHANNELS];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= opcode;
      cov_q    <= covered;
      addr_q   <= addr_wide[ADDR_W-1:0];
      px_q[0]  <= red_in;
      px_q[1]  <= green_in;
      px_q[2]  <= blue_in;
      px_q[3]  <= alpha_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_range_q <= 1'b0;
    end else if (cmd.capture) begin
      in_range_q <= range_ok;
    end
  end

  // Clearing sweep address.
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Voxel RAM: four 8.8 means in the low bits, the sample count above them.
  logic [ADDR_W-1:0]     ram_addr;
  logic                  ram_we;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;
  logic [COUNT_BITS-1:0] cnt_new_q;
  logic [MEAN_W-1:0]     quo [CHANNELS];

  assign ram_addr  = cmd.clr_wr ? clr_addr : addr_q;
  assign ram_we    = cmd.clr_wr | cmd.mem_wr;
  assign ram_wdata = cmd.clr_wr ? '0 : {cnt_new_q, quo[3], quo[2], quo[1], quo[0]};

  vrs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Numerators count*old + new<<8 and the divisor count+1.
  logic [COUNT_BITS-1:0] cnt_old;
  logic [COUNT_BITS:0]   divisor;
  logic [NUM_W-1:0]      num [CHANNELS];

  always_comb begin
    cnt_old = ram_rdata[MEANS_W +: COUNT_BITS];
    divisor = {1'b0, cnt_old} + 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      num[i] = NUM_W'(cnt_old) * NUM_W'(ram_rdata[i*MEAN_W +: MEAN_W]) +
               NUM_W'({px_q[i], 8'h00});
    end
  end

  // The count saturates at its largest value.
  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      cnt_new_q <= (cnt_old == COUNT_MAX) ? cnt_old : cnt_old + 1'b1;
    end
  end

  vrs_div #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.start_div),
    .step    (cmd.div_step),
    .divisor (divisor),
    .num     (num),
    .quo     (quo),
    .last    (sts.div_last)
  );

  // Pending result: zero colors unless a read takes the integer parts.
  logic [BYTE_W-1:0] res_color [CHANNELS];
  logic              res_status;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_status <= !range_ok;
      for (int i = 0; i < CHANNELS; i++) begin
        res_color[i] <= '0;
      end
    end else if (cmd.load_color) begin
      for (int i = 0; i < CHANNELS; i++) begin
        res_color[i] <= ram_rdata[i*MEAN_W + BYTE_W +: BYTE_W];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      red_out   <= res_color[0];
      green_out <= res_color[1];
      blue_out  <= res_color[2];
      alpha_out <= res_color[3];
      status    <= res_status;
    end
  end

  // Status toward the controller.
  assign sts.clr_last = (clr_addr == ADDR_W'(CELLS - 1));
  assign sts.in_range = in_range_q;
  assign sts.is_read  = (op_q == OP_READ);
  assign sts.covered  = cov_q;
  assign sts.out_free = !out_valid || out_ready;

endmodule

>>> rtl/core/voxel_running_average_store.sv
// ----------------------------------------------------------------------------
// voxel_running_average_store: per-voxel running mean of slice pixel colors
// Maps each slice pixel onto a voxel and keeps an RGBA running mean there.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready: an accumulate folds a covered pixel
//   into its voxel's mean, a read returns the voxel's mean bytes. Every
//   request yields exactly one result on out_valid/out_ready; status is 1
//   when the voxel coordinate lies outside the configured dimensions.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Timing:
//   One request at a time. A covered accumulate runs lookup, fetch, the
//   sixteen steps of the shared restoring divider and write-back; a read
//   or uncovered pixel runs lookup and fetch, an out-of-range one lookup.
//   The next request is accepted the cycle after the result is registered.
// Reset:
//   Configuration returns to its defaults and a clearing pass writes zero to
//   all GRID_SIDE^3 voxels (4096 at the default) before in_ready.
// Stall:
//   A waiting result sits in the output register while the next request is
//   taken; a finished request holds until that register frees up.
// ----------------------------------------------------------------------------
module voxel_running_average_store #(
  parameter int GRID_SIDE  = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [vrs_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic [vrs_pkg::COORD_W-1:0]   layer,
  input  logic [vrs_pkg::COORD_W-1:0]   col,
  input  logic [vrs_pkg::COORD_W-1:0]   row,
  input  logic [vrs_pkg::BYTE_W-1:0]    red_in,
  input  logic [vrs_pkg::BYTE_W-1:0]    green_in,
  input  logic [vrs_pkg::BYTE_W-1:0]    blue_in,
  input  logic [vrs_pkg::BYTE_W-1:0]    alpha_in,
  input  logic                          covered,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vrs_pkg::BYTE_W-1:0]    red_out,
  output logic [vrs_pkg::BYTE_W-1:0]    green_out,
  output logic [vrs_pkg::BYTE_W-1:0]    blue_out,
  output logic [vrs_pkg::BYTE_W-1:0]    alpha_out,
  output logic                          status
);

  import vrs_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Controller.
  vrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  vrs_dp #(
    .GRID_SIDE  (GRID_SIDE),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .opcode    (opcode),
    .layer     (layer),
    .col       (col),
    .row       (row),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .alpha_in  (alpha_in),
    .covered   (covered),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .alpha_out (alpha_out),
    .status    (status)
  );

endmodule
